/* rtl/core/gc_trigger_policy_macros.svh */
// assertion helpers shared by the gc trigger policy rtl
`ifndef GC_TRIGGER_POLICY_MACROS_SVH
`define GC_TRIGGER_POLICY_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define GCP_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define GCP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

/* rtl/core/gcp_pkg.sv */
package gcp_pkg;

  // event codes
  localparam logic [1:0] CMD_DONE  = 2'd0;
  localparam logic [1:0] CMD_MINOR = 2'd1;
  localparam logic [1:0] CMD_FULL  = 2'd2;

  // timer delays in ms
  localparam logic [5:0]  MINOR_SOON_MS   = 6'd16;
  localparam logic [5:0]  MINOR_LATE_MS   = 6'd60;
  localparam logic [11:0] FULL_IDLE_MS    = 12'd150;
  localparam logic [11:0] FULL_BUSY_MS    = 12'd300;
  localparam logic [11:0] FULL_RECLAIM_MS = 12'd3000;

  // defer limits and saturation points
  localparam logic [2:0] MINOR_SOON_LIMIT   = 3'd2;
  localparam logic [2:0] MINOR_LATE_LIMIT   = 3'd4;
  localparam logic [2:0] MINOR_DEFER_MAX    = 3'd7;
  localparam logic [3:0] FULL_BUSY_LIMIT    = 4'd3;
  localparam logic [3:0] FULL_RECLAIM_LIMIT = 4'd10;
  localparam logic [3:0] FULL_DEFER_MAX     = 4'd15;

  // plateau handling
  localparam logic [3:0] PLATEAU_LIMIT        = 4'd10;
  localparam logic [3:0] GROWTH_PLATEAU_LIMIT = 4'd5;

  // size thresholds
  localparam logic [47:0] GIB      = 48'd1073741824;
  localparam logic [47:0] HALF_GIB = 48'd536870912;

  // ram size reset and its 7x form kept in the config register
  localparam logic [47:0] RAM_RESET  = 48'd8589934592;
  localparam logic [50:0] RAM7_RESET = 51'(64'd8589934592 * 64'd7);

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] heap_bytes;
    logic [47:0] rss_bytes;
    logic        loop_busy;
    logic        important_work;
    logic [31:0] minor_version;
    logic [31:0] marking_version;
    logic        full_pending;
  } in_t;

  typedef struct packed {
    logic        minor_armed;
    logic [5:0]  minor_delay_ms;
    logic        full_armed;
    logic [11:0] full_delay_ms;
    logic        run_minor;
    logic        run_full;
    logic        release_memory;
  } out_t;

  // pressure verdicts handed to the policy
  typedef struct packed {
    logic pressure;
    logic reclaim_ok;
  } press_t;

endpackage

/* rtl/core/gc_trigger_policy.sv */
// gc trigger policy: decides when minor and full garbage collections run
//
// cmd channel (cmd_valid / cmd_stall / cmd_data): one beat per event, a
//   request completed or a minor or full timer fired, with heap figures
// res channel (res_valid / res_stall / res_data): one beat per event with
//   the timer re-arm requests, collect-now orders and the release hint
// cfg channel (cfg_valid / cfg_ready / cfg_data): writes the ram size;
//   always ready, write it only while no event is in flight
// path: an event taken into the input register passes the decision logic
//   into the result register, from where it is offered on res
// throughput: one event per cycle while res is not stalled; the defer counters
//   and other policy state update as an event moves between the two registers
// reset: all policy state clears, ram size returns to 8 GiB, both
//   channels empty
// res stall: the result register holds its beat, the input register
//   keeps taking one more beat, then cmd_stall rises until res drains
`include "gc_trigger_policy_macros.svh"

module gc_trigger_policy (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  gcp_pkg::in_t  cmd_data,
  output logic          res_valid,
  input  logic          res_stall,
  output gcp_pkg::out_t res_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [47:0]   cfg_data
);

  // ram size kept pre-scaled by 7 for the pressure ratio compares
  logic [50:0] ram7;

  // input register
  logic         s1_valid;
  gcp_pkg::in_t s1_data;

  logic          s1_free;
  logic          s2_free;
  logic          fire;
  gcp_pkg::out_t result;

  assign s2_free   = !res_valid || !res_stall;
  assign fire      = s1_valid && s2_free;
  assign s1_free   = !s1_valid || s2_free;
  assign cmd_stall = !s1_free;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram7 <= gcp_pkg::RAM7_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ram7 <= {cfg_data, 3'b000} - {3'b000, cfg_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && cmd_valid) begin
      s1_data <= cmd_data;
    end
  end

  // decision logic and policy state
  gcp_policy u_policy (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (s1_data),
    .ram7   (ram7),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= result;
    end
  end

  // a blocked event must stay in the input register
  `GCP_CHECK_NEXT(a_hold_s1, s1_valid && !s2_free, s1_valid, "input beat lost while blocked")
  // collect-now and re-arm of the minor timer exclude each other
  `GCP_CHECK(a_minor_excl, res_valid |-> !(res_data.run_minor && res_data.minor_armed), "minor run and re-arm together")
  // memory release only comes with a full collection
  `GCP_CHECK(a_release_full, res_valid |-> (!res_data.release_memory || res_data.run_full), "release without full collection")
  // the full delay is reported exactly when the full timer is armed
  `GCP_CHECK(a_full_delay, res_valid |-> ((res_data.full_delay_ms != 12'd0) == res_data.full_armed), "full delay does not match arm")

endmodule

/* rtl/core/gcp_pressure.sv */
module gcp_pressure (
  input  logic [47:0]   heap_bytes,
  input  logic [47:0]   rss_bytes,
  input  logic [50:0]   ram7,
  input  logic [47:0]   last_heap,
  input  logic [3:0]    plateau_count,
  output gcp_pkg::press_t verdict
);

  logic [51:0] heap_x10;
  logic [51:0] rss_x10;
  logic [49:0] heap_x2;
  logic [49:0] last_x3;
  logic        ratio_hit;
  logic        growth_hit;
  logic        big_hit;

  // x10 as x8 + x2
  assign heap_x10 = {1'b0, heap_bytes, 3'b000} + {3'b000, heap_bytes, 1'b0};
  assign rss_x10  = {1'b0, rss_bytes, 3'b000} + {3'b000, rss_bytes, 1'b0};
  assign heap_x2  = {1'b0, heap_bytes, 1'b0};
  assign last_x3  = {1'b0, last_heap, 1'b0} + {2'b00, last_heap};

  assign ratio_hit  = heap_x10 > {1'b0, ram7};
  assign growth_hit = (last_heap != 48'd0) && (heap_x2 > last_x3) &&
                      (plateau_count < gcp_pkg::GROWTH_PLATEAU_LIMIT);
  assign big_hit    = heap_bytes > gcp_pkg::GIB;

  assign verdict.pressure   = ratio_hit || growth_hit || big_hit;
  assign verdict.reclaim_ok = (heap_bytes > gcp_pkg::HALF_GIB) && (rss_x10 > {1'b0, ram7});

endmodule

/* rtl/core/gcp_policy.sv */
module gcp_policy (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  gcp_pkg::in_t  item,
  input  logic [50:0]   ram7,
  output gcp_pkg::out_t result
);

  logic [47:0] last_heap;
  logic [47:0] last_heap_next;
  logic [3:0]  plateau_count;
  logic [3:0]  plateau_count_next;
  logic [31:0] minor_version_seen;
  logic [31:0] minor_version_seen_next;
  logic [2:0]  minor_defers;
  logic [2:0]  minor_defers_next;
  logic [31:0] full_version_seen;
  logic [31:0] full_version_seen_next;
  logic [3:0]  full_defers;
  logic [3:0]  full_defers_next;
  logic        idle_armed;
  logic        idle_armed_next;

  gcp_pkg::press_t verdict;

  gcp_pressure u_pressure (
    .heap_bytes    (item.heap_bytes),
    .rss_bytes     (item.rss_bytes),
    .ram7          (ram7),
    .last_heap     (last_heap),
    .plateau_count (plateau_count),
    .verdict       (verdict)
  );

  always_comb begin
    logic       grow;
    logic       m_soon;
    logic       f_idle;
    logic       m_new;
    logic       f_new;
    logic [2:0] m_inc;
    logic [3:0] f_inc;
    logic       m_arm;
    logic       f_arm;
    logic       m_call;
    logic       f_call;

    last_heap_next          = last_heap;
    plateau_count_next      = plateau_count;
    minor_version_seen_next = minor_version_seen;
    minor_defers_next       = minor_defers;
    full_version_seen_next  = full_version_seen;
    full_defers_next        = full_defers;
    idle_armed_next         = idle_armed;
    result                  = '0;

    grow   = (item.heap_bytes > last_heap) || verdict.pressure;
    // only the plateau path of a request uses the relaxed variants
    f_idle = (item.command == gcp_pkg::CMD_DONE) && !grow;
    m_soon = !f_idle;

    m_new = (minor_version_seen == 32'd0) || (minor_version_seen != item.minor_version);
    m_inc = (minor_defers < gcp_pkg::MINOR_DEFER_MAX) ? minor_defers + 3'd1 : minor_defers;
    m_arm = m_new || (m_inc < (m_soon ? gcp_pkg::MINOR_SOON_LIMIT
                                      : gcp_pkg::MINOR_LATE_LIMIT));

    f_new = (full_version_seen == 32'd0) || (full_version_seen != item.marking_version);
    f_inc = (full_defers < gcp_pkg::FULL_DEFER_MAX) ? full_defers + 4'd1 : full_defers;
    f_arm = f_new || (f_inc < (f_idle ? gcp_pkg::FULL_RECLAIM_LIMIT
                                      : gcp_pkg::FULL_BUSY_LIMIT));

    m_call = 1'b0;
    f_call = 1'b0;

    case (item.command)
      gcp_pkg::CMD_DONE: begin
        last_heap_next = item.heap_bytes;
        if (grow) begin
          plateau_count_next = 4'd0;
          m_call = !item.important_work;
          f_call = verdict.pressure && !item.full_pending;
        end else if (plateau_count < gcp_pkg::PLATEAU_LIMIT) begin
          m_call = !item.loop_busy && !item.important_work;
          if (m_call && m_arm) begin
            plateau_count_next = plateau_count + 4'd1;
          end
        end else begin
          f_call = !item.loop_busy && !item.important_work;
        end
      end
      gcp_pkg::CMD_MINOR: begin
        m_call = item.loop_busy || item.important_work;
      end
      gcp_pkg::CMD_FULL: begin
        f_call = (item.loop_busy || item.important_work) && !verdict.pressure;
      end
      default: begin
      end
    endcase

    if (m_call) begin
      if (m_new) begin
        minor_version_seen_next = item.minor_version;
        minor_defers_next       = 3'd0;
      end else begin
        minor_defers_next = m_inc;
      end
      if (m_arm) begin
        result.minor_armed    = 1'b1;
        result.minor_delay_ms = m_soon ? gcp_pkg::MINOR_SOON_MS : gcp_pkg::MINOR_LATE_MS;
      end
    end

    if (f_call) begin
      if (f_new) begin
        full_version_seen_next = item.marking_version;
        full_defers_next       = 4'd0;
      end else begin
        full_defers_next = f_inc;
      end
      if (f_arm) begin
        result.full_armed    = 1'b1;
        result.full_delay_ms = f_idle ? gcp_pkg::FULL_RECLAIM_MS :
                               (item.loop_busy ? gcp_pkg::FULL_BUSY_MS
                                               : gcp_pkg::FULL_IDLE_MS);
        idle_armed_next      = f_idle;
      end
    end

    // timer fired and not deferred: collect now and drop the tag
    if ((item.command == gcp_pkg::CMD_MINOR) && !(m_call && m_arm)) begin
      minor_version_seen_next = 32'd0;
      minor_defers_next       = 3'd0;
      result.run_minor        = 1'b1;
    end

    if ((item.command == gcp_pkg::CMD_FULL) && !(f_call && f_arm)) begin
      full_version_seen_next = 32'd0;
      full_defers_next       = 4'd0;
      if (idle_armed) begin
        idle_armed_next       = 1'b0;
        result.release_memory = verdict.reclaim_ok;
      end
      result.run_full = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_heap          <= 48'd0;
      plateau_count      <= 4'd0;
      minor_version_seen <= 32'd0;
      minor_defers       <= 3'd0;
      full_version_seen  <= 32'd0;
      full_defers        <= 4'd0;
      idle_armed         <= 1'b0;
    end else if (fire) begin
      last_heap          <= last_heap_next;
      plateau_count      <= plateau_count_next;
      minor_version_seen <= minor_version_seen_next;
      minor_defers       <= minor_defers_next;
      full_version_seen  <= full_version_seen_next;
      full_defers        <= full_defers_next;
      idle_armed         <= idle_armed_next;
    end
  end

endmodule
